@@ rtl/core/sarb_pkg.sv @@
// Shared types and codes for the send/ack ring buffer.
package sarb_pkg;

  // Fixed field widths.
  localparam int unsigned CountW = 13;
  localparam int unsigned ByteW  = 8;
  localparam int unsigned FuncW  = 3;
  localparam int unsigned StatW  = 2;

  localparam logic [CountW-1:0] RingSizeReset = 13'd4096;

  typedef enum logic [FuncW-1:0] {
    FUNC_RESERVE    = 3'd0,
    FUNC_WRITE      = 3'd1,
    FUNC_PEEK_SENT  = 3'd2,
    FUNC_PEEK_ACKED = 3'd3,
    FUNC_ADV_SENT   = 3'd4,
    FUNC_ADV_ACK    = 3'd5,
    FUNC_REWIND     = 3'd6
  } func_e;

  typedef enum logic [StatW-1:0] {
    ST_DONE   = 2'd0,
    ST_REJECT = 2'd1,
    ST_DROP   = 2'd2
  } status_e;

  typedef struct packed {
    logic [FuncW-1:0]  func;
    logic [CountW-1:0] length;
    logic [ByteW-1:0]  data_byte;
  } in_word_t;

  typedef struct packed {
    logic [StatW-1:0]  status;
    logic [ByteW-1:0]  read_byte;
    logic              last;
    logic [CountW-1:0] unsent_count;
    logic [CountW-1:0] unacked_count;
    logic [CountW-1:0] free_count;
  } out_word_t;

  // Per-command info handed from front to back.
  typedef struct packed {
    logic              is_peek;
    status_e           status;
    logic [CountW-1:0] unsent;
    logic [CountW-1:0] unacked;
    logic [CountW-1:0] free;
  } q_meta_t;

endpackage

@@ rtl/core/send_ack_ring_buffer.sv @@
// Top level of the send/ack byte ring buffer.
//
// Byte ring with write, sent and acked pointers. A word is taken at a clock
// edge with start_i high and busy_o low. The front end handles every word in
// its accept cycle (reserve, write byte, advance, rewind, peek checks) and
// queues one command into a two-entry FIFO; the back end drains that FIFO
// and drives results. Words that give one result stream at one per cycle
// while busy_o stays low. A peek of n bytes gives n results, one read of
// the single memory read port per byte; busy_o rises while the FIFO is full
// behind a long peek. Each result shows on out_word_o for one cycle with
// done_o high, once its word has passed the FIFO and the result register;
// the receiver has no way to stall, so results must be taken as they come.
// The FIFO depth of two also keeps a write from landing on a byte that a
// queued peek has yet to read. The ring memory is not cleared at reset and
// needs no clearing pass. cfg_data_i sets the ring size and clears pointers,
// counts and reservation; write it only while no result is outstanding.
// busy_o is also high while cfg_valid_i is high, so no word is taken in the
// cycle of a size write.
module send_ack_ring_buffer #(
  parameter int unsigned RING_DEPTH = 4096,
  parameter int unsigned MAX_PEEK   = 64
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 start_i,
  output logic                 busy_o,
  input  sarb_pkg::in_word_t   in_word_i,
  output logic                 done_o,
  output sarb_pkg::out_word_t  out_word_o,
  input  logic                 cfg_valid_i,
  output logic                 cfg_ready_o,
  input  logic [12:0]          cfg_data_i
);
  import sarb_pkg::*;

  localparam int unsigned PW = $clog2(RING_DEPTH);
  localparam int unsigned NW = $clog2(MAX_PEEK + 1);
  localparam int unsigned QW = $bits(q_meta_t) + PW + NW;

  logic          accept, cfg_we, push, full, q_valid, q_pop, we;
  q_meta_t       f_meta, b_meta;
  logic [PW-1:0] f_ptr, b_ptr, waddr;
  logic [NW-1:0] f_n, b_n;
  logic [7:0]    wdata;
  logic [12:0]   size;
  logic [QW-1:0] q_in, q_out;

  assign cfg_ready_o = 1'b1;
  assign cfg_we      = cfg_valid_i && cfg_ready_o;
  assign busy_o      = full || cfg_valid_i;
  assign accept      = start_i && !busy_o;

  sarb_front #(
    .RING_DEPTH(RING_DEPTH),
    .MAX_PEEK  (MAX_PEEK)
  ) u_front (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .accept_i  (accept),
    .in_word_i (in_word_i),
    .cfg_we_i  (cfg_we),
    .cfg_data_i(cfg_data_i),
    .push_o    (push),
    .meta_o    (f_meta),
    .ptr_o     (f_ptr),
    .n_o       (f_n),
    .we_o      (we),
    .waddr_o   (waddr),
    .wdata_o   (wdata),
    .size_o    (size)
  );

  assign q_in = {f_meta, f_ptr, f_n};

  sarb_queue #(
    .W(QW)
  ) u_queue (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .push_i (push),
    .data_i (q_in),
    .full_o (full),
    .valid_o(q_valid),
    .data_o (q_out),
    .pop_i  (q_pop)
  );

  assign {b_meta, b_ptr, b_n} = q_out;

  sarb_back #(
    .RING_DEPTH(RING_DEPTH),
    .MAX_PEEK  (MAX_PEEK)
  ) u_back (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .q_valid_i (q_valid),
    .q_meta_i  (b_meta),
    .q_ptr_i   (b_ptr),
    .q_n_i     (b_n),
    .q_pop_o   (q_pop),
    .we_i      (we),
    .waddr_i   (waddr),
    .wdata_i   (wdata),
    .size_i    (size),
    .done_o    (done_o),
    .out_word_o(out_word_o)
  );

endmodule

@@ rtl/core/sarb_front.sv @@
// Front end: accepts words, updates pointers and counts, issues commands.
module sarb_front #(
  parameter int unsigned RING_DEPTH = 4096,
  parameter int unsigned MAX_PEEK   = 64
) (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      accept_i,
  input  sarb_pkg::in_word_t        in_word_i,
  input  logic                      cfg_we_i,
  input  logic [12:0]               cfg_data_i,
  output logic                      push_o,
  output sarb_pkg::q_meta_t         meta_o,
  output logic [$clog2(RING_DEPTH)-1:0]   ptr_o,
  output logic [$clog2(MAX_PEEK+1)-1:0]   n_o,
  output logic                      we_o,
  output logic [$clog2(RING_DEPTH)-1:0]   waddr_o,
  output logic [7:0]                wdata_o,
  output logic [12:0]               size_o
);
  import sarb_pkg::*;

  localparam int unsigned PW = $clog2(RING_DEPTH);
  localparam int unsigned NW = $clog2(MAX_PEEK + 1);
  localparam int unsigned AW = ((PW > CountW) ? PW : CountW) + 1;

  logic [CountW-1:0] ring_size_q, ring_size_d;
  logic [PW-1:0]     wr_ptr_q, wr_ptr_d, sent_ptr_q, sent_ptr_d, ack_ptr_q, ack_ptr_d;
  logic [CountW-1:0] unsent_q, unsent_d, unacked_q, unacked_d, resv_q, resv_d;
  logic [CountW-1:0] sz, free_now, len, pending;
  logic [NW-1:0]     n_sel;

  function automatic logic [PW-1:0] wrap_add(input logic [PW-1:0] p,
                                             input logic [CountW-1:0] a,
                                             input logic [CountW-1:0] s);
    logic [AW-1:0] t;
    t = AW'(p) + AW'(a);
    if (t >= AW'(s)) t = t - AW'(s);
    return t[PW-1:0];
  endfunction

  function automatic logic [CountW-1:0] free_of(input logic [CountW-1:0] a,
                                                input logic [CountW-1:0] b,
                                                input logic [CountW-1:0] c,
                                                input logic [CountW-1:0] s);
    logic [CountW+1:0] used;
    used = (CountW+2)'(a) + (CountW+2)'(b) + (CountW+2)'(c);
    return (used >= (CountW+2)'(s)) ? '0 : CountW'((CountW+2)'(s) - used);
  endfunction

  // Effective ring size: zero acts as one, clamp to the array depth.
  always_comb begin
    if (ring_size_q == '0) begin
      sz = CountW'(1);
    end else if (32'(ring_size_q) > RING_DEPTH) begin
      sz = CountW'(RING_DEPTH);
    end else begin
      sz = ring_size_q;
    end
  end

  assign free_now = free_of(unsent_q, unacked_q, resv_q, sz);
  assign len      = in_word_i.length;
  assign n_sel    = (32'(len) > MAX_PEEK) ? NW'(MAX_PEEK) : NW'(len);
  assign pending  = (func_e'(in_word_i.func) == FUNC_PEEK_SENT) ? unsent_q : unacked_q;

  always_comb begin
    ring_size_d    = ring_size_q;
    wr_ptr_d       = wr_ptr_q;
    sent_ptr_d     = sent_ptr_q;
    ack_ptr_d      = ack_ptr_q;
    unsent_d       = unsent_q;
    unacked_d      = unacked_q;
    resv_d         = resv_q;
    meta_o.is_peek = 1'b0;
    meta_o.status  = ST_DONE;
    ptr_o          = '0;
    n_o            = '0;
    we_o           = 1'b0;
    waddr_o        = wr_ptr_q;
    wdata_o        = in_word_i.data_byte;

    if (cfg_we_i) begin
      ring_size_d = cfg_data_i;
      wr_ptr_d    = '0;
      sent_ptr_d  = '0;
      ack_ptr_d   = '0;
      unsent_d    = '0;
      unacked_d   = '0;
      resv_d      = '0;
    end else if (accept_i) begin
      case (func_e'(in_word_i.func))
        FUNC_RESERVE: begin
          if (len <= free_now) resv_d = resv_q + len;
          else meta_o.status = ST_REJECT;
        end
        FUNC_WRITE: begin
          if (resv_q != '0) begin
            we_o     = 1'b1;
            wr_ptr_d = wrap_add(wr_ptr_q, CountW'(1), sz);
            resv_d   = resv_q - CountW'(1);
            unsent_d = unsent_q + CountW'(1);
          end else begin
            meta_o.status = ST_DROP;
          end
        end
        FUNC_PEEK_SENT, FUNC_PEEK_ACKED: begin
          if (pending < CountW'(n_sel)) begin
            meta_o.status = ST_REJECT;
          end else if (n_sel != '0) begin
            meta_o.is_peek = 1'b1;
            n_o            = n_sel;
            ptr_o = (func_e'(in_word_i.func) == FUNC_PEEK_SENT) ? sent_ptr_q : ack_ptr_q;
          end
        end
        FUNC_ADV_SENT: begin
          if (unsent_q < len) begin
            meta_o.status = ST_REJECT;
          end else begin
            sent_ptr_d = wrap_add(sent_ptr_q, len, sz);
            unsent_d   = unsent_q - len;
            unacked_d  = unacked_q + len;
          end
        end
        FUNC_ADV_ACK: begin
          if (unacked_q < len) begin
            meta_o.status = ST_REJECT;
          end else begin
            ack_ptr_d = wrap_add(ack_ptr_q, len, sz);
            unacked_d = unacked_q - len;
          end
        end
        FUNC_REWIND: begin
          sent_ptr_d = ack_ptr_q;
          unsent_d   = unsent_q + unacked_q;
          unacked_d  = '0;
        end
        default: begin
        end
      endcase
    end

    // Counts reported are those after the word takes effect.
    meta_o.unsent  = unsent_d;
    meta_o.unacked = unacked_d;
    meta_o.free    = free_of(unsent_d, unacked_d, resv_d, sz);
  end

  assign push_o         = accept_i && !cfg_we_i;
  assign size_o         = sz;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ring_size_q <= RingSizeReset;
      wr_ptr_q    <= '0;
      sent_ptr_q  <= '0;
      ack_ptr_q   <= '0;
      unsent_q    <= '0;
      unacked_q   <= '0;
      resv_q      <= '0;
    end else begin
      ring_size_q <= ring_size_d;
      wr_ptr_q    <= wr_ptr_d;
      sent_ptr_q  <= sent_ptr_d;
      ack_ptr_q   <= ack_ptr_d;
      unsent_q    <= unsent_d;
      unacked_q   <= unacked_d;
      resv_q      <= resv_d;
    end
  end

endmodule

@@ rtl/core/sarb_queue.sv @@
// Two-entry command FIFO between front and back.
module sarb_queue #(
  parameter int unsigned W = 8
) (
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         push_i,
  input  logic [W-1:0] data_i,
  output logic         full_o,
  output logic         valid_o,
  output logic [W-1:0] data_o,
  input  logic         pop_i
);
  import sarb_pkg::*;

  localparam int unsigned Depth = 2;
  localparam int unsigned IW    = $clog2(Depth);

  logic [W-1:0]  ent_q [Depth];
  logic [IW-1:0] rd_q, rd_d, wr_q, wr_d;
  logic [IW:0]   cnt_q, cnt_d;
  logic          do_push, do_pop;

  assign full_o  = (cnt_q == (IW+1)'(Depth));
  assign valid_o = (cnt_q != '0);
  assign data_o  = ent_q[rd_q];
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && valid_o;

  always_comb begin
    rd_d  = do_pop  ? rd_q + IW'(1) : rd_q;
    wr_d  = do_push ? wr_q + IW'(1) : wr_q;
    cnt_d = cnt_q + (IW+1)'(do_push) - (IW+1)'(do_pop);
  end

  always_ff @(posedge clk_i) begin
    if (do_push) ent_q[wr_q] <= data_i;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rd_q  <= '0;
      wr_q  <= '0;
      cnt_q <= '0;
    end else begin
      rd_q  <= rd_d;
      wr_q  <= wr_d;
      cnt_q <= cnt_d;
    end
  end

endmodule

@@ rtl/core/sarb_back.sv @@
// Back end: ring memory, peek sequencer and result register.
module sarb_back #(
  parameter int unsigned RING_DEPTH = 4096,
  parameter int unsigned MAX_PEEK   = 64
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            q_valid_i,
  input  sarb_pkg::q_meta_t               q_meta_i,
  input  logic [$clog2(RING_DEPTH)-1:0]   q_ptr_i,
  input  logic [$clog2(MAX_PEEK+1)-1:0]   q_n_i,
  output logic                            q_pop_o,
  input  logic                            we_i,
  input  logic [$clog2(RING_DEPTH)-1:0]   waddr_i,
  input  logic [7:0]                      wdata_i,
  input  logic [12:0]                     size_i,
  output logic                            done_o,
  output sarb_pkg::out_word_t             out_word_o
);
  import sarb_pkg::*;

  localparam int unsigned PW = $clog2(RING_DEPTH);
  localparam int unsigned NW = $clog2(MAX_PEEK + 1);
  localparam int unsigned AW = ((PW > CountW) ? PW : CountW) + 1;

  logic [ByteW-1:0] mem [RING_DEPTH];
  logic [ByteW-1:0] rd_q;
  logic [NW-1:0]    off_q, off_d;
  logic             done_q, last_q, last_beat, issue;
  q_meta_t          meta_q;
  logic [AW-1:0]    sum;
  logic [PW-1:0]    raddr;

  assign issue     = q_valid_i;
  assign last_beat = !q_meta_i.is_peek || ((NW+1)'(off_q) + (NW+1)'(1) == (NW+1)'(q_n_i));
  assign q_pop_o   = issue && last_beat;
  assign off_d     = q_pop_o ? '0 : (issue ? off_q + NW'(1) : off_q);

  // Beat address, wrapped once at the ring size.
  assign sum   = AW'(q_ptr_i) + AW'(off_q);
  assign raddr = (sum >= AW'(size_i)) ? PW'(sum - AW'(size_i)) : PW'(sum);

  always_ff @(posedge clk_i) begin
    if (we_i) mem[waddr_i] <= wdata_i;
    if (issue && q_meta_i.is_peek) rd_q <= mem[raddr];
    if (issue) begin
      meta_q <= q_meta_i;
      last_q <= last_beat;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      off_q  <= '0;
      done_q <= 1'b0;
    end else begin
      off_q  <= off_d;
      done_q <= issue;
    end
  end

  assign done_o                   = done_q;
  assign out_word_o.status        = meta_q.status;
  assign out_word_o.read_byte     = meta_q.is_peek ? rd_q : '0;
  assign out_word_o.last          = last_q;
  assign out_word_o.unsent_count  = meta_q.unsent;
  assign out_word_o.unacked_count = meta_q.unacked;
  assign out_word_o.free_count    = meta_q.free;

endmodule
